// ----- hdl/lrb_pkg.sv -----
// Shared types and constants of the link reconnect backoff controller.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package lrb_pkg;

	// Reported link state, also the stored connection mode
	typedef enum logic [2:0] {
		ST_DISABLED   = 3'd0,
		ST_IDLE       = 3'd1,
		ST_CONNECTING = 3'd2,
		ST_CONNECTED  = 3'd3,
		ST_FAILED     = 3'd4
	} link_state_t;

	// Event reported with each result
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_UP   = 2'd1,
		EV_DOWN = 2'd2
	} link_event_t;

	// Configuration port geometry and register indexes
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MAX = 8'd3;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 32'd12000;
	localparam logic [CFG_DATA_W-1:0] BASE_RST    = 32'd2000;
	localparam logic [CFG_DATA_W-1:0] MAX_RST     = 32'd60000;

	// Failure counter
	localparam int FAIL_W = 8;
	localparam logic [FAIL_W-1:0] FAIL_MAX = 8'd255;

	// Backoff delay register: one bit of headroom over a doubled config value
	localparam int DELAY_W = CFG_DATA_W + 1;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // take the poll into the input register
		logic dly_load;  // start the backoff doubling loop
		logic dly_step;  // one doubling
		logic commit;    // update link state and write the result register
	} lrb_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_backoff; // this poll ends a timed-out attempt
		logic dly_done;     // backoff loop finished
		logic out_free;     // result register can take a new result
	} lrb_sts_t;

endpackage

`default_nettype wire

// ----- hdl/lrb_poll_if.sv -----
// Poll, result and configuration channel interfaces.
// Depends on lrb_pkg for field widths.
`default_nettype none

interface lrb_poll_if #(
	parameter int TIME_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [TIME_WIDTH-1:0] now_ms;
	logic                  link_up;

	modport source (output valid, output now_ms, output link_up, input ready);
	modport sink (input valid, input now_ms, input link_up, output ready);
endinterface

interface lrb_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] link_state;
	logic       start_attempt;
	logic [1:0] link_event;
	logic [7:0] failure_count;

	modport source (output valid, output link_state, output start_attempt,
		output link_event, output failure_count, input ready);
	modport sink (input valid, input link_state, input start_attempt,
		input link_event, input failure_count, output ready);
endinterface

interface lrb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lrb_pkg::CFG_IDX_W-1:0]  index;
	logic [lrb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lrb_ctrl.sv -----
// Sequencing controller of the link reconnect backoff block.
// Depends on lrb_pkg (command and status structs).
`default_nettype none

module lrb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              poll_valid,
	output logic                   poll_ready,
	input  wire lrb_pkg::lrb_sts_t sts,
	output lrb_pkg::lrb_cmd_t      cmd
);
	import lrb_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DLY
	} ctrl_state_t;

	ctrl_state_t state_q;

	// Hold state; advance on capture, backoff and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (poll_valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (sts.need_backoff) state_q <= S_DLY;
					else if (sts.out_free) state_q <= S_IDLE;
				end
				S_DLY: begin
					if (sts.dly_done && sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Decode commands from state and status
	always_comb begin
		cmd        = '0;
		poll_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				poll_ready  = 1'b1;
				cmd.capture = poll_valid;
			end
			S_EVAL: begin
				cmd.dly_load = sts.need_backoff;
				cmd.commit   = !sts.need_backoff && sts.out_free;
			end
			S_DLY: begin
				cmd.dly_step = !sts.dly_done;
				cmd.commit   = sts.dly_done && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/lrb_dp.sv -----
// Datapath of the link reconnect backoff block: configuration registers,
// poll register, link mode and timers, backoff doubling loop, result register.
// Depends on lrb_pkg.
`default_nettype none

module lrb_dp #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire lrb_pkg::lrb_cmd_t                  cmd,
	output lrb_pkg::lrb_sts_t                       sts,
	// poll payload
	input  wire logic [TIME_WIDTH-1:0]              poll_now_ms,
	input  wire logic                               poll_link_up,
	// configuration writes
	input  wire logic                               cfg_we,
	input  wire logic [lrb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lrb_pkg::CFG_DATA_W-1:0]      cfg_data,
	// result channel
	output logic                                    res_valid,
	input  wire logic                               res_ready,
	output logic [2:0]                              res_link_state,
	output logic                                    res_start_attempt,
	output logic [1:0]                              res_link_event,
	output logic [lrb_pkg::FAIL_W-1:0]               res_failure_count
);
	import lrb_pkg::*;

	// Common width for time and delay sums and compares
	localparam int WW = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;

	// Configuration registers
	logic                  enabled_q;
	logic [CFG_DATA_W-1:0] timeout_q;
	logic [CFG_DATA_W-1:0] base_q;
	logic [CFG_DATA_W-1:0] max_q;

	// Poll register
	logic [TIME_WIDTH-1:0] now_q;
	logic                  link_up_q;

	// Link state
	link_state_t           mode_q;
	logic [TIME_WIDTH-1:0] start_time_q;
	logic [TIME_WIDTH-1:0] next_time_q;
	logic [FAIL_W-1:0]     failures_q;

	// Backoff loop
	logic [DELAY_W-1:0]    delay_q;
	logic [FAIL_W-1:0]     step_q;
	logic [FAIL_W-1:0]     count_q;

	// Result register
	logic                  out_valid_q;
	link_state_t           out_state_q;
	logic                  out_start_q;
	link_event_t           out_event_q;
	logic [FAIL_W-1:0]     out_fail_q;

	logic [TIME_WIDTH-1:0] elapsed;
	logic                  timed_out;
	logic                  due;
	logic [FAIL_W-1:0]     fail_inc;
	logic [DELAY_W-1:0]    max_ext;
	logic                  dly_more;
	logic [CFG_DATA_W-1:0] delay_cap;
	logic [TIME_WIDTH-1:0] lost_next;
	logic [TIME_WIDTH-1:0] retry_next;

	link_state_t           mode_d;
	logic [TIME_WIDTH-1:0] start_time_d;
	logic [TIME_WIDTH-1:0] next_time_d;
	logic [FAIL_W-1:0]     failures_d;
	logic                  start_d;
	link_event_t           event_d;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			timeout_q <= TIMEOUT_RST;
			base_q    <= BASE_RST;
			max_q     <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLED:      enabled_q <= cfg_data[0];
				REG_TIMEOUT_MS:   timeout_q <= cfg_data;
				REG_BACKOFF_BASE: base_q    <= cfg_data;
				REG_BACKOFF_MAX:  max_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the accepted poll
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q     <= poll_now_ms;
			link_up_q <= poll_link_up;
		end
	end

	// Attempt timing and scheduled-retry tests
	assign elapsed   = now_q - start_time_q;
	assign timed_out = WW'(elapsed) > WW'(timeout_q);
	assign due       = now_q >= next_time_q;
	assign fail_inc  = (failures_q == FAIL_MAX) ? failures_q : failures_q + 1'b1;
	assign lost_next = TIME_WIDTH'(WW'(now_q) + WW'(base_q));

	// Backoff loop: double while below the cap and failures remain
	assign max_ext    = {1'b0, max_q};
	assign dly_more   = (step_q < count_q) && (delay_q < max_ext) && (delay_q != '0);
	assign delay_cap  = (delay_q > max_ext) ? max_q : delay_q[CFG_DATA_W-1:0];
	assign retry_next = TIME_WIDTH'(WW'(now_q) + WW'(delay_cap));

	always_ff @(posedge clk) begin
		if (cmd.dly_load) begin
			delay_q <= {1'b0, base_q};
			step_q  <= '0;
			count_q <= fail_inc;
		end else if (cmd.dly_step) begin
			delay_q <= {delay_q[DELAY_W-2:0], 1'b0};
			step_q  <= step_q + 1'b1;
		end
	end

	// Next link state for the held poll
	always_comb begin
		mode_d       = mode_q;
		start_time_d = start_time_q;
		next_time_d  = next_time_q;
		failures_d   = failures_q;
		start_d      = 1'b0;
		event_d      = EV_NONE;
		unique case (mode_q) inside
			ST_IDLE, ST_FAILED: begin
				if (due) begin
					start_time_d = now_q;
					mode_d       = ST_CONNECTING;
					start_d      = 1'b1;
				end
			end
			ST_CONNECTING: begin
				if (link_up_q) begin
					mode_d     = ST_CONNECTED;
					failures_d = '0;
					event_d    = EV_UP;
				end else if (timed_out) begin
					failures_d  = fail_inc;
					mode_d      = ST_FAILED;
					next_time_d = retry_next;
				end
			end
			ST_CONNECTED: begin
				if (!link_up_q) begin
					mode_d      = ST_FAILED;
					next_time_d = lost_next;
					event_d     = EV_DOWN;
				end
			end
			default: mode_d = ST_IDLE;
		endcase
	end

	// Commit link state; hold everything while disabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ST_IDLE;
			start_time_q <= '0;
			next_time_q  <= '0;
			failures_q   <= '0;
		end else if (cmd.commit && enabled_q) begin
			mode_q       <= mode_d;
			start_time_q <= start_time_d;
			next_time_q  <= next_time_d;
			failures_q   <= failures_d;
		end
	end

	// Result register: set on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_state_q <= enabled_q ? mode_d : ST_DISABLED;
			out_start_q <= enabled_q && start_d;
			out_event_q <= enabled_q ? event_d : EV_NONE;
			out_fail_q  <= enabled_q ? failures_d : failures_q;
		end
	end

	assign res_valid         = out_valid_q;
	assign res_link_state    = out_state_q;
	assign res_start_attempt = out_start_q;
	assign res_link_event    = out_event_q;
	assign res_failure_count = out_fail_q;

	// Status to the controller
	assign sts.need_backoff = enabled_q && (mode_q == ST_CONNECTING) && !link_up_q
		&& timed_out;
	assign sts.dly_done     = !dly_more;
	assign sts.out_free     = !out_valid_q || res_ready;

	// A commit never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || res_ready))
		else $error("result register overwritten");

	// A commit always presents a result next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit without result");

	// The doubling loop never steps past its end
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dly_step |-> dly_more)
		else $error("backoff step after loop end");

	// A saturated failure count only holds or clears
	a_fail_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(failures_q == FAIL_MAX) |=> (failures_q == FAIL_MAX || failures_q == '0))
		else $error("failure count wrapped");

endmodule

`default_nettype wire

// ----- hdl/link_reconnect_backoff_fsm.sv -----
// Top level of the link reconnect controller with capped exponential backoff.
// Depends on lrb_pkg, the channel interfaces, lrb_ctrl and lrb_dp.
//
//   channel  dir  handshake      payload
//   poll     in   valid/ready    now_ms[TIME_WIDTH], link_up
//   result   out  valid/ready    link_state[3], start_attempt, link_event[2],
//                                failure_count[8]
//   cfg      in   valid/ready    index[8], data[32]; ready is always high
//
// A poll is captured, then evaluated and committed. A poll that ends a timed-out
// attempt also runs the backoff loop of n doublings between evaluation and commit
// (n at most 32), one doubling per cycle.
// One poll is in flight at a time; a finished result waits in the result
// register while the next poll is taken, and a full result register stalls
// the commit. Reset gives idle mode, zero timers and counts, disabled.
`default_nettype none

module link_reconnect_backoff_fsm #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lrb_poll_if.sink     poll,
	lrb_result_if.source result,
	lrb_cfg_if.sink      cfg
);
	import lrb_pkg::*;

	lrb_cmd_t cmd;
	lrb_sts_t sts;
	logic     poll_ready;

	assign poll.ready = poll_ready;
	assign cfg.ready  = 1'b1;

	lrb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll.valid),
		.poll_ready (poll_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	lrb_dp #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.poll_now_ms       (poll.now_ms),
		.poll_link_up      (poll.link_up),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.res_valid         (result.valid),
		.res_ready         (result.ready),
		.res_link_state    (result.link_state),
		.res_start_attempt (result.start_attempt),
		.res_link_event    (result.link_event),
		.res_failure_count (result.failure_count)
	);

endmodule

`default_nettype wire
